### src/concatenated_segment_locator_assert.svh
// Assertion macros used by the checker file.
`ifndef CONCATENATED_SEGMENT_LOCATOR_ASSERT_SVH
`define CONCATENATED_SEGMENT_LOCATOR_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define CSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csl assertion failed");

// next-cycle implication, disabled while reset is held
`define CSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csl assertion failed");

`endif

### src/csl_pkg.sv
package csl_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int COUNT_BITS   = 20;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 20;
    localparam int POS_W    = 26;
    localparam int STATUS_W = 2;
    localparam int SEG_W    = 6;
    localparam int OFFSET_W = 20;
    localparam int TOTAL_W  = 26;
    localparam int HELD_W   = 7;

    // derived
    localparam int IDX_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int DEPTH  = MAX_SEGMENTS + 1;
    localparam int ADD_W  = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
    localparam int SUM_W  = TOTAL_W + 1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

### src/csl_ram.sv
module csl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/concatenated_segment_locator.sv
// Segment locator: keeps cumulative boundaries of appended segments in a
// single-port-read RAM and answers each beat (append, lookup, clear) with one
// result beat. Append, clear, the unused opcode and an out-of-range lookup pass
// from accept through the execute and finish states; an in-range lookup with
// more than one segment held adds a binary search in the probe state, one
// binary-search probe per cycle through the RAM read port and one boundary
// comparator. o_stall is high from the cycle after accept until the result
// is loaded into the output register; a held result does not block the next
// accept, but the next beat waits in its last cycle until the output register
// is free. Boundary RAM needs no init pass after reset: only written entries are
// ever read.
module concatenated_segment_locator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [csl_pkg::OP_W-1:0]         i_operation,
    input  logic [csl_pkg::COUNT_W-1:0]      i_chunk_count,
    input  logic [csl_pkg::POS_W-1:0]        i_position,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [csl_pkg::STATUS_W-1:0]     o_status,
    output logic [csl_pkg::SEG_W-1:0]        o_segment,
    output logic [csl_pkg::OFFSET_W-1:0]     o_offset,
    output logic                             o_reopen,
    output logic [csl_pkg::TOTAL_W-1:0]      o_total_chunks,
    output logic [csl_pkg::HELD_W-1:0]       o_segments_held
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_PROBE  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [csl_pkg::OP_W-1:0]     r_op, n_op;
    logic [csl_pkg::ADD_W-1:0]    r_count, n_count;
    logic [csl_pkg::POS_W-1:0]    r_pos, n_pos;
    logic [csl_pkg::IDX_W-1:0]    r_lo, n_lo;
    logic [csl_pkg::IDX_W-1:0]    r_hi, n_hi;
    logic [csl_pkg::IDX_W-1:0]    r_mid, n_mid;
    logic [csl_pkg::TOTAL_W-1:0]  r_lo_bound, n_lo_bound;
    logic [csl_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic [csl_pkg::IDX_W-1:0]    r_seg_total, n_seg_total;
    logic                         r_sel_valid, n_sel_valid;
    logic [csl_pkg::IDX_W-1:0]    r_sel_seg, n_sel_seg;
    logic [csl_pkg::STATUS_W-1:0] r_status, n_status;

    logic                          r_out_valid, n_out_valid;
    logic [csl_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic [csl_pkg::SEG_W-1:0]     r_out_segment, n_out_segment;
    logic [csl_pkg::OFFSET_W-1:0]  r_out_offset, n_out_offset;
    logic                          r_out_reopen, n_out_reopen;
    logic [csl_pkg::TOTAL_W-1:0]   r_out_total, n_out_total;
    logic [csl_pkg::HELD_W-1:0]    r_out_held, n_out_held;

    logic                         ram_we;
    logic [csl_pkg::IDX_W-1:0]    ram_waddr;
    logic [csl_pkg::TOTAL_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [csl_pkg::IDX_W-1:0]    ram_raddr;
    logic [csl_pkg::TOTAL_W-1:0]  ram_rdata;

    logic [csl_pkg::SUM_W-1:0]    w_sum;
    logic [csl_pkg::TOTAL_W-1:0]  w_new_bound;
    logic                         w_go_up;
    logic [csl_pkg::IDX_W-1:0]    w_lo, w_hi, w_span, w_next_mid;
    logic [csl_pkg::TOTAL_W-1:0]  w_pos_diff;
    logic                         w_out_free;
    logic                         w_found;

    csl_ram #(
        .WIDTH (csl_pkg::TOTAL_W),
        .DEPTH (csl_pkg::DEPTH)
    ) u_bound_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // saturating append sum
    assign w_sum       = csl_pkg::SUM_W'(r_total) + csl_pkg::SUM_W'(r_count);
    assign w_new_bound = w_sum[csl_pkg::TOTAL_W] ? csl_pkg::TOTAL_MAX
                                                 : w_sum[csl_pkg::TOTAL_W-1:0];

    // one search step: ram_rdata is boundaries[r_mid]
    assign w_go_up    = (ram_rdata <= r_pos);
    assign w_lo       = w_go_up ? r_mid : r_lo;
    assign w_hi       = w_go_up ? r_hi : r_mid;
    assign w_span     = w_hi - w_lo;
    assign w_next_mid = w_lo + (w_span >> 1);

    assign w_pos_diff = r_pos - r_lo_bound;
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_found    = (r_op == csl_pkg::OP_LOOKUP) && (r_status == csl_pkg::ST_OK);

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_count       = r_count;
        n_pos         = r_pos;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_lo_bound    = r_lo_bound;
        n_total       = r_total;
        n_seg_total   = r_seg_total;
        n_sel_valid   = r_sel_valid;
        n_sel_seg     = r_sel_seg;
        n_status      = r_status;
        n_out_valid   = r_out_valid && i_stall;
        n_out_status  = r_out_status;
        n_out_segment = r_out_segment;
        n_out_offset  = r_out_offset;
        n_out_reopen  = r_out_reopen;
        n_out_total   = r_out_total;
        n_out_held    = r_out_held;
        ram_we        = 1'b0;
        ram_waddr     = r_seg_total + csl_pkg::IDX_W'(1);
        ram_wdata     = w_new_bound;
        ram_re        = 1'b0;
        ram_raddr     = r_mid;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_count = i_chunk_count[csl_pkg::ADD_W-1:0];
                    n_pos   = i_position;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = csl_pkg::ST_OK;
                n_state  = S_FINISH;
                case (r_op)
                    csl_pkg::OP_APPEND: begin
                        if (r_seg_total >= csl_pkg::IDX_W'(csl_pkg::MAX_SEGMENTS)) begin
                            n_status = csl_pkg::ST_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            n_total     = w_new_bound;
                            n_seg_total = r_seg_total + csl_pkg::IDX_W'(1);
                        end
                    end
                    csl_pkg::OP_LOOKUP: begin
                        n_lo       = '0;
                        n_hi       = r_seg_total;
                        n_lo_bound = '0;
                        // empty table has total zero, so it lands here too
                        if (r_pos >= r_total) begin
                            n_status = csl_pkg::ST_RANGE;
                        end else if (r_seg_total > csl_pkg::IDX_W'(1)) begin
                            n_mid     = r_seg_total >> 1;
                            ram_re    = 1'b1;
                            ram_raddr = r_seg_total >> 1;
                            n_state   = S_PROBE;
                        end
                    end
                    csl_pkg::OP_CLEAR: begin
                        n_seg_total = '0;
                        n_total     = '0;
                        n_sel_valid = 1'b0;
                        n_sel_seg   = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_PROBE: begin
                n_lo  = w_lo;
                n_hi  = w_hi;
                n_mid = w_next_mid;
                if (w_go_up) begin
                    n_lo_bound = ram_rdata;
                end
                if (w_span > csl_pkg::IDX_W'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = w_next_mid;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_total   = r_total;
                    n_out_held    = csl_pkg::HELD_W'(r_seg_total);
                    n_out_segment = '0;
                    n_out_offset  = '0;
                    n_out_reopen  = 1'b0;
                    if (w_found) begin
                        n_out_segment = csl_pkg::SEG_W'(r_lo);
                        n_out_offset  = csl_pkg::OFFSET_W'(w_pos_diff);
                        n_out_reopen  = !r_sel_valid || (r_sel_seg != r_lo);
                        n_sel_valid   = 1'b1;
                        n_sel_seg     = r_lo;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_seg_total <= '0;
            r_sel_valid <= 1'b0;
            r_sel_seg   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_seg_total <= n_seg_total;
            r_sel_valid <= n_sel_valid;
            r_sel_seg   <= n_sel_seg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op          <= n_op;
        r_count       <= n_count;
        r_pos         <= n_pos;
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_lo_bound    <= n_lo_bound;
        r_status      <= n_status;
        r_out_status  <= n_out_status;
        r_out_segment <= n_out_segment;
        r_out_offset  <= n_out_offset;
        r_out_reopen  <= n_out_reopen;
        r_out_total   <= n_out_total;
        r_out_held    <= n_out_held;
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_segment       = r_out_segment;
    assign o_offset        = r_out_offset;
    assign o_reopen        = r_out_reopen;
    assign o_total_chunks  = r_out_total;
    assign o_segments_held = r_out_held;

endmodule

### src/csl_checker.sv
`include "concatenated_segment_locator_assert.svh"

module csl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [csl_pkg::STATUS_W-1:0]     o_status,
    input logic [csl_pkg::SEG_W-1:0]        o_segment,
    input logic [csl_pkg::OFFSET_W-1:0]     o_offset,
    input logic                             o_reopen,
    input logic [csl_pkg::TOTAL_W-1:0]      o_total_chunks,
    input logic [csl_pkg::HELD_W-1:0]       o_segments_held
);

    // stalled result beat holds
    `CSL_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_segment) && $stable(o_offset) && $stable(o_reopen) && $stable(o_total_chunks) && $stable(o_segments_held))

    // failed beats carry no location
    `CSL_ASSERT_NOW(a_fail_zero, o_valid && (o_status != csl_pkg::ST_OK), (o_segment == '0) && (o_offset == '0) && !o_reopen)

    // only a full table refuses an append
    `CSL_ASSERT_NOW(a_full_held, o_valid && (o_status == csl_pkg::ST_FULL), o_segments_held == csl_pkg::HELD_W'(csl_pkg::MAX_SEGMENTS))

    // a nonzero offset needs a nonempty range
    `CSL_ASSERT_NOW(a_offset_total, o_valid && (o_offset != '0), o_total_chunks != '0)

endmodule

bind concatenated_segment_locator csl_checker u_csl_checker (.*);
